[sv/nrmc_pkg.sv]
// Package for the RMC sentence parser: phase encoding, character constants,
// result record and small decode helpers. No dependencies.
package nrmc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_DIGIT1,
    PH_DIGIT2
  } phase_t;

  localparam logic [2:0] HEADER_LEN = 3'd5;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ACTIVE  = 8'h41;
  localparam logic [3:0] FIELD_MAX  = 4'hF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] field_number;
    logic       field_byte_valid;
    logic       sentence_end;
    logic       checksum_ok;
    logic       fix_active;
  } res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  // Expected header character at each match position ("GPRMC").
  function automatic logic [7:0] rmc_tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h4D;
      3'd4:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Uppercase hex digit decode; anything else flags bad and yields zero.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

[sv/nmea_rmc_sentence_parser.sv]
// Top level of the RMC sentence parser: input register, parse step, result
// register with valid/ready on both sides. Depends on nrmc_pkg and nrmc_parse.
// Path: an accepted byte waits in the input register and steps into the result register, which drives out_*.
// Throughput: one byte per cycle; the input register refills while the result
// register drains, so only a stalled out_ready slows acceptance.
// Reset: synchronous active-low rst_n empties both registers and returns the
// parser to hunting for '$' with all sentence state cleared.
module nmea_rmc_sentence_parser import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_field_number,
  output logic       out_field_byte_valid,
  output logic       out_sentence_end,
  output logic       out_checksum_ok,
  output logic       out_fix_active
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  res_t       res_r;
  res_t       step_res;
  logic       adv;

  // advance the held byte into the result register when it is free
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv) begin
      res_r <= step_res;
    end
  end

  nrmc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .rx_byte (in_byte_r),
    .res     (step_res)
  );

  assign out_valid            = out_valid_r;
  assign out_data_byte        = res_r.data_byte;
  assign out_field_number     = res_r.field_number;
  assign out_field_byte_valid = res_r.field_byte_valid;
  assign out_sentence_end     = res_r.sentence_end;
  assign out_checksum_ok      = res_r.checksum_ok;
  assign out_fix_active       = res_r.fix_active;

  a_ok_needs_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_checksum_ok || out_fix_active) |-> out_sentence_end)
    else $error("checksum_ok or fix_active without sentence_end");

  a_content_not_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_field_byte_valid && out_sentence_end))
    else $error("content byte flagged as sentence end");

  a_hold_input : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost or overwritten");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

[sv/nrmc_parse.sv]
// Parse state registers and the per-byte step logic of the RMC parser.
// Depends on nrmc_pkg.
module nrmc_parse import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] hpos_r, hpos_nxt;
  logic [7:0] cks_r, cks_nxt;
  logic [3:0] fcnt_r, fcnt_nxt;
  logic       active_r, active_nxt;
  logic [3:0] hi_nib_r, hi_nib_nxt;
  logic       dig_err_r, dig_err_nxt;
  hex_t       hx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      hpos_r    <= 3'd0;
      cks_r     <= 8'h00;
      fcnt_r    <= 4'h0;
      active_r  <= 1'b0;
      hi_nib_r  <= 4'h0;
      dig_err_r <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hpos_r    <= hpos_nxt;
      cks_r     <= cks_nxt;
      fcnt_r    <= fcnt_nxt;
      active_r  <= active_nxt;
      hi_nib_r  <= hi_nib_nxt;
      dig_err_r <= dig_err_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    hpos_nxt    = hpos_r;
    cks_nxt     = cks_r;
    fcnt_nxt    = fcnt_r;
    active_nxt  = active_r;
    hi_nib_nxt  = hi_nib_r;
    dig_err_nxt = dig_err_r;
    hx          = hex_decode(rx_byte);

    res                  = '0;
    res.data_byte        = rx_byte;

    if (rx_byte == CH_DOLLAR) begin
      // restart header match from any phase
      phase_nxt   = PH_HEADER;
      hpos_nxt    = 3'd0;
      cks_nxt     = 8'h00;
      fcnt_nxt    = 4'h0;
      active_nxt  = 1'b0;
      hi_nib_nxt  = 4'h0;
      dig_err_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          cks_nxt = cks_r ^ rx_byte;
          if (hpos_r < HEADER_LEN && rx_byte == rmc_tag_char(hpos_r)) begin
            if (hpos_r == HEADER_LEN - 3'd1) begin
              phase_nxt = PH_BODY;
              hpos_nxt  = 3'd0;
              fcnt_nxt  = 4'h0;
            end else begin
              hpos_nxt = hpos_r + 3'd1;
            end
          end else begin
            phase_nxt = PH_IDLE;
            hpos_nxt  = 3'd0;
          end
        end
        PH_BODY: begin
          res.field_number = fcnt_r;
          if (rx_byte == CH_STAR) begin
            phase_nxt = PH_DIGIT1;
          end else if (rx_byte == CH_CR) begin
            // abort: end without a checksum
            res.sentence_end = 1'b1;
            res.fix_active   = active_r;
            phase_nxt        = PH_IDLE;
            hpos_nxt         = 3'd0;
          end else if (rx_byte == CH_COMMA) begin
            cks_nxt  = cks_r ^ rx_byte;
            fcnt_nxt = (fcnt_r != FIELD_MAX) ? fcnt_r + 4'h1 : fcnt_r;
            hpos_nxt = 3'd0;
            res.field_number = fcnt_nxt;
          end else begin
            cks_nxt = cks_r ^ rx_byte;
            // first content byte of the status field sets the fix flag
            if (fcnt_r == 4'd2 && hpos_r == 3'd0) begin
              active_nxt = (rx_byte == CH_ACTIVE);
            end
            hpos_nxt             = 3'd1;
            res.field_byte_valid = 1'b1;
          end
        end
        PH_DIGIT1: begin
          hi_nib_nxt       = hx.nib;
          dig_err_nxt      = hx.bad;
          phase_nxt        = PH_DIGIT2;
          res.field_number = fcnt_r;
        end
        PH_DIGIT2: begin
          dig_err_nxt      = dig_err_r | hx.bad;
          res.field_number = fcnt_r;
          res.sentence_end = 1'b1;
          res.checksum_ok  = !dig_err_r && !hx.bad && ({hi_nib_r, hx.nib} == cks_r);
          res.fix_active   = active_r;
          phase_nxt        = PH_IDLE;
          hpos_nxt         = 3'd0;
        end
        default: begin
          phase_nxt = PH_IDLE;
          hpos_nxt  = 3'd0;
        end
      endcase
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for nmea_rmc_sentence_parser: short directed byte runs, then
// random RMC sentences and line noise with random idling on both sides.
// Depends on nrmc_pkg and the parser RTL; a scoreboard class predicts each result.
module testbench;
  import nrmc_pkg::*;

  localparam logic [39:0] RMC_HEADER  = "GPRMC";
  localparam logic [7:0]  CH_VOID     = 8'h56;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam int          ITEM_COUNT  = 1600;
  localparam int          HOLDOFF_AT  = 500;
  localparam int          HOLDOFF_LEN = 400;
  localparam int          CYCLE_LIMIT = 300000;

  class rmc_scoreboard;
    phase_t     phase;
    logic [2:0] hdr_pos;
    logic [7:0] xor_sum;
    logic [3:0] field_idx;
    logic       status_a;
    logic [3:0] hi_nib;
    logic       digit_bad;
    res_t       predicted_outputs[$];
    int         errors;

    function new();
      phase     = PH_IDLE;
      hdr_pos   = '0;
      xor_sum   = '0;
      field_idx = '0;
      status_a  = 1'b0;
      hi_nib    = '0;
      digit_bad = 1'b0;
      errors    = 0;
    endfunction

    function void decode_digit(input logic [7:0] c, output logic bad, output logic [3:0] nib);
      bad = 1'b0;
      nib = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
        nib = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        nib = 4'(c - 8'h41 + 8'd10);
      end else begin
        bad = 1'b1;
      end
    endfunction

    // Advance the parse state by one accepted byte and queue its result.
    function void note_rx_byte(input logic [7:0] c);
      res_t       r;
      logic       bad;
      logic [3:0] nib;
      r = '0;
      r.data_byte = c;
      if (c == CH_DOLLAR) begin
        phase     = PH_HEADER;
        hdr_pos   = '0;
        xor_sum   = '0;
        field_idx = '0;
        status_a  = 1'b0;
        hi_nib    = '0;
        digit_bad = 1'b0;
      end else begin
        case (phase)
          PH_HEADER: begin
            xor_sum = xor_sum ^ c;
            if (hdr_pos < HEADER_LEN && c == RMC_HEADER[8 * (4 - hdr_pos) +: 8]) begin
              hdr_pos = hdr_pos + 3'd1;
              if (hdr_pos == HEADER_LEN) begin
                phase     = PH_BODY;
                hdr_pos   = '0;
                field_idx = '0;
              end
            end else begin
              phase   = PH_IDLE;
              hdr_pos = '0;
            end
          end
          PH_BODY: begin
            r.field_number = field_idx;
            if (c == CH_STAR) begin
              phase = PH_DIGIT1;
            end else if (c == CH_CR) begin
              r.sentence_end = 1'b1;
              r.fix_active   = status_a;
              phase          = PH_IDLE;
              hdr_pos        = '0;
            end else if (c == CH_COMMA) begin
              xor_sum = xor_sum ^ c;
              if (field_idx != FIELD_MAX) field_idx = field_idx + 4'd1;
              hdr_pos        = '0;
              r.field_number = field_idx;
            end else begin
              xor_sum = xor_sum ^ c;
              // only the first byte of the status field sets the fix
              if (field_idx == 4'd2 && hdr_pos == 3'd0) status_a = (c == CH_ACTIVE);
              hdr_pos            = 3'd1;
              r.field_byte_valid = 1'b1;
            end
          end
          PH_DIGIT1: begin
            decode_digit(c, bad, nib);
            hi_nib         = nib;
            digit_bad      = bad;
            phase          = PH_DIGIT2;
            r.field_number = field_idx;
          end
          PH_DIGIT2: begin
            decode_digit(c, bad, nib);
            if (bad) digit_bad = 1'b1;
            r.field_number = field_idx;
            r.sentence_end = 1'b1;
            r.checksum_ok  = !digit_bad && ({hi_nib, nib} == xor_sum);
            r.fix_active   = status_a;
            phase          = PH_IDLE;
            hdr_pos        = '0;
          end
          default: begin
            phase   = PH_IDLE;
            hdr_pos = '0;
          end
        endcase
      end
      predicted_outputs.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_parsed(input res_t got);
      res_t want;
      if (predicted_outputs.size() == 0) begin
        $error("result with none pending: data_byte %h", got.data_byte);
        errors++;
        return;
      end
      want = predicted_outputs.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("field_number", 8'(want.field_number), 8'(got.field_number));
      compare_field("field_byte_valid", 8'(want.field_byte_valid), 8'(got.field_byte_valid));
      compare_field("sentence_end", 8'(want.sentence_end), 8'(got.sentence_end));
      compare_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
      compare_field("fix_active", 8'(want.fix_active), 8'(got.fix_active));
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_data_byte;
  logic [3:0] out_field_number;
  logic       out_field_byte_valid;
  logic       out_sentence_end;
  logic       out_checksum_ok;
  logic       out_fix_active;

  rmc_scoreboard parse_sb;
  logic [7:0]    sentence_bytes[$];
  int            accepted_bytes = 0;
  int            cycle_count    = 0;
  bit            send_steady    = 1'b0;
  bit            recv_steady    = 1'b0;
  bit            holdoff_done   = 1'b0;

  nmea_rmc_sentence_parser u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_byte        (out_data_byte),
    .out_field_number     (out_field_number),
    .out_field_byte_valid (out_field_byte_valid),
    .out_sentence_end     (out_sentence_end),
    .out_checksum_ok      (out_checksum_ok),
    .out_fix_active       (out_fix_active)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nmea_rmc_sentence_parser: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 15))
      0:       return CH_LF;
      1:       return 8'($urandom_range(0, 255));
      2:       return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom_range(8'h30, 8'h5A));
    endcase
  endfunction

  function automatic void push_text(input string s);
    foreach (s[i]) sentence_bytes.push_back(s[i]);
  endfunction

  // Append '*' and the two digits of the XOR over everything after the '$'.
  function automatic void append_checksum();
    logic [7:0] sum;
    int         start;
    sum   = '0;
    start = 0;
    foreach (sentence_bytes[i]) if (sentence_bytes[i] == CH_DOLLAR) start = i + 1;
    for (int i = start; i < sentence_bytes.size(); i++) sum = sum ^ sentence_bytes[i];
    sentence_bytes.push_back(CH_STAR);
    sentence_bytes.push_back(hex_char(sum[7:4]));
    sentence_bytes.push_back(hex_char(sum[3:0]));
  endfunction

  task automatic build_random_sentence();
    int nfields;
    int len;
    int idx;
    sentence_bytes = {};
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) sentence_bytes.push_back(8'($urandom_range(0, 255)));
    end
    sentence_bytes.push_back(CH_DOLLAR);
    for (int k = 0; k < 5; k++) begin
      if ($urandom_range(0, 15) == 0) sentence_bytes.push_back(8'($urandom_range(0, 255)));
      else sentence_bytes.push_back(RMC_HEADER[8 * (4 - k) +: 8]);
    end
    // push past the field counter's ceiling now and then
    nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 13);
    if ($urandom_range(0, 7) == 0) sentence_bytes.push_back(field_char());
    for (int f = 1; f <= nfields; f++) begin
      sentence_bytes.push_back(CH_COMMA);
      if (f == 2) begin
        case ($urandom_range(0, 4))
          0, 1:    sentence_bytes.push_back(CH_ACTIVE);
          2:       sentence_bytes.push_back(CH_VOID);
          3:       sentence_bytes.push_back(field_char());
          default: ;
        endcase
        len = $urandom_range(0, 2);
      end else begin
        len = $urandom_range(0, 3);
      end
      repeat (len) sentence_bytes.push_back(field_char());
    end
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
        append_checksum();
        idx = sentence_bytes.size() - 1 - $urandom_range(0, 1);
        case ($urandom_range(0, 10))
          7:  sentence_bytes[idx] = hex_char(4'($urandom_range(0, 15)));
          8:  sentence_bytes[idx] = 8'($urandom_range(8'h61, 8'h66));
          9:  sentence_bytes[idx] = 8'($urandom_range(0, 255));
          10: sentence_bytes[idx] = CH_CR;
          default: ;
        endcase
      end
      14, 15, 16: sentence_bytes.push_back(CH_CR);
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_sb.note_rx_byte(b);
    accepted_bytes++;
  endtask

  task automatic send_sentence();
    foreach (sentence_bytes[i]) send_byte(sentence_bytes[i]);
  endtask

  initial begin
    parse_sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle extremes, good sentence, CR abort with empty status,
    // header mismatch, dollar restart inside the header.
    sentence_bytes = {8'h00, 8'hFF};
    push_text("$GPRMC,,A");
    append_checksum();
    push_text("$GPRMC,,");
    sentence_bytes.push_back(CH_CR);
    push_text("$GPX$GP");
    send_sentence();

    while (accepted_bytes < ITEM_COUNT) begin
      if ($urandom_range(0, 7) == 0) send_steady = !send_steady;
      if ($urandom_range(0, 7) == 0) recv_steady = !recv_steady;
      build_random_sentence();
      send_sentence();
    end
    in_valid <= 1'b0;

    while (parse_sb.predicted_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (parse_sb.errors == 0) begin
      $display("nmea_rmc_sentence_parser: match");
    end else begin
      $display("nmea_rmc_sentence_parser: mismatch");
    end
    $finish;
  end

  initial begin
    int   stall;
    res_t got;
    while (!rst_n) @(posedge clk);
    forever begin
      // hold off once for a long stretch so the parser backs up into its input
      if (!holdoff_done && accepted_bytes >= HOLDOFF_AT) begin
        stall        = HOLDOFF_LEN;
        holdoff_done = 1'b1;
      end else begin
        stall = recv_steady ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {out_data_byte, out_field_number, out_field_byte_valid, out_sentence_end,
             out_checksum_ok, out_fix_active};
      parse_sb.check_parsed(got);
    end
  end

endmodule
